/* sv/mrfw_pkg.sv */
// Shared types, constants and color helpers for the marker rectangle fill writer.
`timescale 1ns / 1ps
`default_nettype none

package mrfw_pkg;

    // Grid defaults and fixed geometry.
    localparam int MARKER_SIZE_DEF   = 8;
    localparam int MARKER_STRIDE_DEF = 10;
    localparam int GROUP_SIZE_DEF    = 10;
    localparam int MARKER_BASE       = 2;
    localparam int LINE_STRIDE       = 10;

    // Field widths.
    localparam int IDX_W      = 16;
    localparam int CHAN_W     = 8;
    localparam int OFF_W      = 29;
    localparam int PIX_W      = 32;
    localparam int PITCH_W    = 16;
    localparam int COORD_W    = 13;
    localparam int SHIFT_W    = 5;
    localparam int CWID_W     = 12;
    localparam int SY_W       = 20;
    localparam int CELL_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_PITCH     = 3'd0,
        CFG_SCREEN_WIDTH   = 3'd1,
        CFG_SCREEN_HEIGHT  = 3'd2,
        CFG_RED_SHIFT      = 3'd3,
        CFG_GREEN_SHIFT    = 3'd4,
        CFG_BLUE_SHIFT     = 3'd5,
        CFG_CHANNEL_WIDTHS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [IDX_W-1:0]  marker_index;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0] byte_offset;
        logic [PIX_W-1:0] pixel_word;
        logic             last_write;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [IDX_W-1:0]  quot;
        logic [CELL_W-1:0] rem;
    } t_div_rsp;

    // Scales a byte to a mask width: v * (2^w - 1) / 255, with the divide by 255
    // done as (p + (p >> 8) + 1) >> 8, which is exact for the products here.
    function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] v,
                                                        input logic [3:0] bits);
        logic [15:0] prod;
        logic [15:0] quo;
        prod = 16'(v) * ((16'd1 << bits[2:0]) - 16'd1);
        quo  = (prod + (prod >> 8) + 16'd1) >> 8;
        if (bits == 4'd0) begin
            return '0;
        end else if (bits[3]) begin
            return v;
        end else begin
            return quo[CHAN_W-1:0];
        end
    endfunction

    function automatic logic [PIX_W-1:0] place_channel(input logic [CHAN_W-1:0] s,
                                                       input logic [SHIFT_W-1:0] sh);
        return {{(PIX_W-CHAN_W){1'b0}}, s} << sh;
    endfunction

endpackage

`default_nettype wire

/* sv/mrfw_div.sv */
// Divider of the marker index by the grid row length, done by reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module mrfw_div #(
    parameter int DIVISOR = mrfw_pkg::GROUP_SIZE_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire mrfw_pkg::t_div_req i_req,
    output mrfw_pkg::t_div_rsp      o_rsp
);
    import mrfw_pkg::*;

    // With the shift one rounded-up log2 step past the dividend width, the rounded-up
    // reciprocal gives the exact quotient for every dividend of IDX_W bits.
    localparam int SHIFT   = IDX_W + $clog2(DIVISOR);
    localparam int RECIP_W = IDX_W + 1;
    localparam int PROD_W  = IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic              r_busy;
    logic              r_split;
    logic              r_done;
    logic [IDX_W-1:0]  r_dvd;
    logic [IDX_W-1:0]  r_quo;
    logic [CELL_W-1:0] r_rem;

    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  back;

    assign prod = PROD_W'(r_dvd) * PROD_W'(RECIP);
    assign back = r_quo * IDX_W'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_split <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_req.dividend;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_quo   <= IDX_W'(prod >> SHIFT);
                r_split <= 1'b1;
            end else if (r_split) begin
                // The remainder is computed from the registered quotient.
                r_split <= 1'b0;
                r_rem   <= CELL_W'(r_dvd - back);
                r_done  <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

/* sv/marker_rect_fill_writer.sv */
// Top level: places a colored marker square in a grid and streams its pixel writes.
//
//  Channel | Direction | Handshake                    | Payload
//  --------+-----------+------------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready    | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// A request passes through the divider, where a reciprocal multiply splits the index
// into grid row and column, then through clipping, the row multiply and the start offset.
// After that one write leaves per cycle while the sink is ready, up to 64 writes, and
// the next request is taken only once the last write of a marker is out; a marker
// off screen returns the block to idle after clipping, with no writes at all.
// The input is ready only while the sequencer is idle, a stalled sink holds the write,
// and the synchronous reset loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module marker_rect_fill_writer #(
    parameter int MARKER_SIZE   = mrfw_pkg::MARKER_SIZE_DEF,
    parameter int MARKER_STRIDE = mrfw_pkg::MARKER_STRIDE_DEF,
    parameter int GROUP_SIZE    = mrfw_pkg::GROUP_SIZE_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  mrfw_pkg::t_in_item            i_in_item,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output mrfw_pkg::t_out_item                 o_out_item,
    input  wire                                 i_cfg_we,
    input  wire  [mrfw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [mrfw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mrfw_pkg::*;

    localparam int CNT_W = (MARKER_SIZE > 1) ? $clog2(MARKER_SIZE) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CLIP,
        S_MUL,
        S_BASE,
        S_EMIT
    } t_state;

    // Configuration registers.
    logic [PITCH_W-1:0] r_line_pitch;
    logic [COORD_W-1:0] r_screen_width;
    logic [COORD_W-1:0] r_screen_height;
    logic [SHIFT_W-1:0] r_red_shift;
    logic [SHIFT_W-1:0] r_green_shift;
    logic [SHIFT_W-1:0] r_blue_shift;
    logic [CWID_W-1:0]  r_channel_widths;

    t_state             r_state;
    logic               r_div_start;
    logic               r_out_valid;
    t_in_item           r_item;
    logic [IDX_W-1:0]   r_group;
    logic [CELL_W-1:0]  r_cell;
    logic [COORD_W-1:0] r_sx;
    logic [SY_W-1:0]    r_sy;
    logic [CNT_W-1:0]   r_w_last;
    logic [CNT_W-1:0]   r_h_last;
    logic [CNT_W-1:0]   r_x;
    logic [CNT_W-1:0]   r_y;
    logic [PIX_W-1:0]   r_pixel;
    logic [OFF_W-1:0]   r_prod;
    logic [OFF_W-1:0]   r_row_off;
    logic [OFF_W-1:0]   r_off;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [COORD_W-1:0] sx_c;
    logic [SY_W-1:0]    sy_c;
    logic [COORD_W-1:0] w_rem;
    logic [SY_W-1:0]    h_rem;
    logic               visible;
    logic               is_last;
    logic [PIX_W-1:0]   pixel_c;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_item.marker_index;

    mrfw_div #(
        .DIVISOR(GROUP_SIZE)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        sx_c    = COORD_W'(MARKER_BASE) + COORD_W'(int'(r_cell) * MARKER_STRIDE);
        sy_c    = SY_W'(MARKER_BASE) + SY_W'(r_group * SY_W'(LINE_STRIDE));
        visible = (sx_c < r_screen_width) && (sy_c < SY_W'(r_screen_height));
        w_rem   = r_screen_width - sx_c;
        h_rem   = SY_W'(r_screen_height) - sy_c;
        pixel_c = place_channel(scale_channel(r_item.red_in, r_channel_widths[11:8]),
                                r_red_shift)
                | place_channel(scale_channel(r_item.green_in, r_channel_widths[7:4]),
                                r_green_shift)
                | place_channel(scale_channel(r_item.blue_in, r_channel_widths[3:0]),
                                r_blue_shift);
    end

    assign is_last = (r_x == r_w_last) && (r_y == r_h_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pitch     <= '0;
            r_screen_width   <= '0;
            r_screen_height  <= '0;
            r_red_shift      <= SHIFT_W'(16);
            r_green_shift    <= SHIFT_W'(8);
            r_blue_shift     <= '0;
            r_channel_widths <= CWID_W'(12'h888);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_PITCH:     r_line_pitch     <= i_cfg_data;
                CFG_SCREEN_WIDTH:   r_screen_width   <= i_cfg_data[COORD_W-1:0];
                CFG_SCREEN_HEIGHT:  r_screen_height  <= i_cfg_data[COORD_W-1:0];
                CFG_RED_SHIFT:      r_red_shift      <= i_cfg_data[SHIFT_W-1:0];
                CFG_GREEN_SHIFT:    r_green_shift    <= i_cfg_data[SHIFT_W-1:0];
                CFG_BLUE_SHIFT:     r_blue_shift     <= i_cfg_data[SHIFT_W-1:0];
                CFG_CHANNEL_WIDTHS: r_channel_widths <= i_cfg_data[CWID_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item      <= i_in_item;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_group <= div_rsp.quot;
                        r_cell  <= div_rsp.rem;
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    r_sx    <= sx_c;
                    r_sy    <= sy_c;
                    r_pixel <= pixel_c;
                    r_x     <= '0;
                    r_y     <= '0;
                    if (w_rem < COORD_W'(MARKER_SIZE)) begin
                        r_w_last <= CNT_W'(w_rem - 1'b1);
                    end else begin
                        r_w_last <= CNT_W'(MARKER_SIZE - 1);
                    end
                    if (h_rem < SY_W'(MARKER_SIZE)) begin
                        r_h_last <= CNT_W'(h_rem - 1'b1);
                    end else begin
                        r_h_last <= CNT_W'(MARKER_SIZE - 1);
                    end
                    r_state <= visible ? S_MUL : S_IDLE;
                end
                S_MUL: begin
                    r_prod  <= OFF_W'(r_sy) * OFF_W'(r_line_pitch);
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_row_off   <= r_prod + OFF_W'({r_sx, 2'b00});
                    r_off       <= r_prod + OFF_W'({r_sx, 2'b00});
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        if (is_last) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else if (r_x == r_w_last) begin
                            // Next row starts one pitch below the current row start.
                            r_x       <= '0;
                            r_y       <= r_y + 1'b1;
                            r_row_off <= r_row_off + OFF_W'(r_line_pitch);
                            r_off     <= r_row_off + OFF_W'(r_line_pitch);
                        end else begin
                            r_x   <= r_x + 1'b1;
                            r_off <= r_off + OFF_W'(4);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready             = (r_state == S_IDLE);
    assign o_out_valid            = r_out_valid;
    assign o_out_item.byte_offset = r_off;
    assign o_out_item.pixel_word  = r_pixel;
    assign o_out_item.last_write  = is_last;

endmodule

`default_nettype wire

/* sv/mrfw_chk.sv */
// Port-level checker for the marker rectangle fill writer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mrfw_chk (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      o_in_ready,
    input wire                      o_out_valid,
    input wire                      i_out_ready,
    input wire mrfw_pkg::t_out_item o_out_item
);
    import mrfw_pkg::*;

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // A pending write stays offered with the same contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output write dropped or changed while stalled");

    // The block never takes a new request while writes are still going out.
    a_busy_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while writes are pending");

    a_take_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("ready held after a request was taken");

    // The final write ends the stream; any other write is followed by the next one.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out_item.last_write |=> !o_out_valid)
        else $error("write offered after the final write");

    a_stream_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_out_item.last_write |=> o_out_valid && $stable(o_out_item.pixel_word))
        else $error("write stream broke or changed color within one marker");

endmodule

bind marker_rect_fill_writer mrfw_chk u_mrfw_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_item (o_out_item)
);

`default_nettype wire

/* test/marker_rect_fill_writer_tb.sv */
// Self-checking testbench for marker_rect_fill_writer: grid placement, clipping, color packing.
`timescale 1ns / 1ps

module marker_rect_fill_writer_tb;
    import mrfw_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Copy of the register file as the block should hold it.
    logic [PITCH_W-1:0] shadow_pitch;
    logic [COORD_W-1:0] shadow_width;
    logic [COORD_W-1:0] shadow_height;
    logic [SHIFT_W-1:0] shadow_red_shift;
    logic [SHIFT_W-1:0] shadow_green_shift;
    logic [SHIFT_W-1:0] shadow_blue_shift;
    logic [CWID_W-1:0]  shadow_widths;

    t_out_item   pending_writes[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_hold_req = 0;
    bit          sink_quiet = 1'b0;
    bit          sender_quiet = 1'b0;

    marker_rect_fill_writer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [CHAN_W-1:0] scaled_level(logic [CHAN_W-1:0] v, logic [3:0] bits);
        int unsigned prod;
        if (bits == 4'd0)
            return '0;
        if (bits >= 4'd8)
            return v;
        prod = int'(v) * ((1 << bits) - 1);
        return CHAN_W'(prod / 255);
    endfunction

    function automatic logic [PIX_W-1:0] shifted_level(logic [CHAN_W-1:0] v,
                                                       logic [SHIFT_W-1:0] sh);
        logic [63:0] wide;
        wide = 64'(v) << sh;
        return wide[PIX_W-1:0];
    endfunction

    // Works out every pixel write of one marker, in row-major order.
    function automatic void predict_marker(t_in_item it);
        int unsigned group, slot, sx, sy, cols, rows, total, n;
        logic [PIX_W-1:0] pixel;
        logic [63:0]      off;
        t_out_item        wr;
        group = it.marker_index / GROUP_SIZE_DEF;
        slot  = it.marker_index % GROUP_SIZE_DEF;
        sx    = MARKER_BASE + slot * MARKER_STRIDE_DEF;
        sy    = MARKER_BASE + group * LINE_STRIDE;
        if (sx >= shadow_width || sy >= shadow_height)
            return;
        cols = (sx + MARKER_SIZE_DEF > shadow_width) ? shadow_width - sx : MARKER_SIZE_DEF;
        rows = (sy + MARKER_SIZE_DEF > shadow_height) ? shadow_height - sy : MARKER_SIZE_DEF;
        pixel = shifted_level(scaled_level(it.red_in, shadow_widths[11:8]), shadow_red_shift)
              | shifted_level(scaled_level(it.green_in, shadow_widths[7:4]), shadow_green_shift)
              | shifted_level(scaled_level(it.blue_in, shadow_widths[3:0]), shadow_blue_shift);
        total = cols * rows;
        n = 0;
        for (int unsigned y = 0; y < rows; y++) begin
            for (int unsigned x = 0; x < cols; x++) begin
                off = 64'(sy + y) * 64'(shadow_pitch) + 64'(sx + x) * 64'd4;
                wr.byte_offset = off[OFF_W-1:0];
                wr.pixel_word  = pixel;
                wr.last_write  = (n + 1 == total);
                pending_writes.push_back(wr);
                n++;
            end
        end
    endfunction

    // Write sink: draws a stall after each accepted write and checks every accepted one.
    initial begin : write_sink
        int unsigned gap;
        t_out_item   want;
        gap = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (pending_writes.size() == 0) begin
                    $error("unexpected write: byte_offset %0h pixel_word %0h last_write %0b",
                           out_item.byte_offset, out_item.pixel_word, out_item.last_write);
                    mismatch_count++;
                end else begin
                    want = pending_writes.pop_front();
                    if (out_item.byte_offset !== want.byte_offset) begin
                        $error("byte_offset: expected %0h, got %0h",
                               want.byte_offset, out_item.byte_offset);
                        mismatch_count++;
                    end
                    if (out_item.pixel_word !== want.pixel_word) begin
                        $error("pixel_word: expected %0h, got %0h",
                               want.pixel_word, out_item.pixel_word);
                        mismatch_count++;
                    end
                    if (out_item.last_write !== want.last_write) begin
                        $error("last_write: expected %0b, got %0b",
                               want.last_write, out_item.last_write);
                        mismatch_count++;
                    end
                end
                gap = sink_quiet ? 0 : $urandom_range(0, 3);
            end
            if (sink_hold_req > 0) begin
                gap = sink_hold_req;
                sink_hold_req = 0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                gap--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(t_cfg_idx reg_idx, int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= reg_idx;
        cfg_data <= CFG_DATA_W'(value);
        case (reg_idx)
            CFG_LINE_PITCH:     shadow_pitch       = PITCH_W'(value);
            CFG_SCREEN_WIDTH:   shadow_width       = COORD_W'(value);
            CFG_SCREEN_HEIGHT:  shadow_height      = COORD_W'(value);
            CFG_RED_SHIFT:      shadow_red_shift   = SHIFT_W'(value);
            CFG_GREEN_SHIFT:    shadow_green_shift = SHIFT_W'(value);
            CFG_BLUE_SHIFT:     shadow_blue_shift  = SHIFT_W'(value);
            CFG_CHANNEL_WIDTHS: shadow_widths      = CWID_W'(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_screen(int unsigned pitch, int unsigned width, int unsigned height);
        write_reg(CFG_LINE_PITCH, pitch);
        write_reg(CFG_SCREEN_WIDTH, width);
        write_reg(CFG_SCREEN_HEIGHT, height);
    endtask

    task automatic apply_color(int unsigned rs, int unsigned gs, int unsigned bs,
                               int unsigned widths);
        write_reg(CFG_RED_SHIFT, rs);
        write_reg(CFG_GREEN_SHIFT, gs);
        write_reg(CFG_BLUE_SHIFT, bs);
        write_reg(CFG_CHANNEL_WIDTHS, widths);
    endtask

    // Valid stays high after a request is taken so that a back-to-back
    // request never lowers and raises it in the same step.
    task automatic send_marker(logic [IDX_W-1:0] idx, logic [CHAN_W-1:0] r,
                               logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
        int unsigned gap;
        t_in_item    it;
        gap = sender_quiet ? 0 : $urandom_range(0, 3);
        it.marker_index = idx;
        it.red_in       = r;
        it.green_in     = g;
        it.blue_in      = b;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_marker(it);
    endtask

    task automatic send_random_color(logic [IDX_W-1:0] idx);
        send_marker(idx, CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                    CHAN_W'($urandom_range(0, 255)));
    endtask

    // Lets the block finish; an off-screen request keeps it busy with no write to wait for.
    task automatic drain_writes();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [IDX_W-1:0] visible_index();
        int unsigned group;
        group = $urandom_range(0, shadow_height / LINE_STRIDE);
        return IDX_W'(group * GROUP_SIZE_DEF + $urandom_range(0, GROUP_SIZE_DEF - 1));
    endfunction

    // After reset the screen is zero by zero, so nothing is drawn.
    task automatic test_reset_defaults();
        send_marker(16'd0, 8'hFF, 8'hFF, 8'hFF);
        drain_writes();
    endtask

    task automatic test_grid_placement();
        apply_screen(3200, 800, 600);
        send_marker(16'd0, 8'h00, 8'h00, 8'h00);
        send_marker(16'd9, 8'hFF, 8'hFF, 8'hFF);
        send_marker(16'd10, 8'h80, 8'h40, 8'h01);
        send_marker(16'd589, 8'h12, 8'h34, 8'h56);
        send_marker(16'd600, 8'hAA, 8'h55, 8'hAA);
        send_marker(16'hFFFF, 8'h55, 8'hAA, 8'h55);
        drain_writes();
    endtask

    task automatic test_clipping();
        apply_screen(3200, 97, 15);
        send_marker(16'd19, 8'h11, 8'h22, 8'h33);
        send_marker(16'd9, 8'h44, 8'h55, 8'h66);
        send_marker(16'd10, 8'h77, 8'h88, 8'h99);
        drain_writes();
        // Start column exactly on the right edge, then one column inside it.
        apply_screen(3200, 52, 8191);
        send_marker(16'd5, 8'hFF, 8'h00, 8'hFF);
        drain_writes();
        apply_screen(3200, 53, 8191);
        send_marker(16'd5, 8'h00, 8'hFF, 8'h00);
        drain_writes();
        apply_screen(3200, 3, 3);
        send_marker(16'd0, 8'hC3, 8'h3C, 8'h81);
        drain_writes();
        apply_screen(3200, 0, 600);
        send_marker(16'd0, 8'hFF, 8'hFF, 8'hFF);
        drain_writes();
    endtask

    task automatic test_color_packing();
        apply_screen(65535, 800, 600);
        apply_color(16, 8, 0, 12'h000);
        send_marker(16'd0, 8'hFF, 8'hFF, 8'hFF);
        drain_writes();
        apply_color(0, 8, 16, 12'h123);
        send_marker(16'd1, 8'hFF, 8'hFF, 8'hFF);
        send_marker(16'd2, 8'd200, 8'd100, 8'd7);
        drain_writes();
        // Fields shifted past bit 24 lose their upper bits.
        apply_color(31, 24, 28, 12'h7F8);
        send_marker(16'd3, 8'hFF, 8'h80, 8'h01);
        drain_writes();
        apply_color(31, 31, 31, 12'hFFF);
        send_marker(16'd4, 8'hAA, 8'h55, 8'hFF);
        drain_writes();
        apply_color(4, 13, 22, 12'h456);
        send_marker(16'd5, 8'h01, 8'hFE, 8'h7F);
        drain_writes();
    endtask

    task automatic test_pitch_extremes();
        apply_color(16, 8, 0, 12'h888);
        apply_screen(0, 8191, 8191);
        send_marker(16'd8189, 8'h10, 8'h20, 8'h30);
        drain_writes();
        apply_screen(65535, 8191, 8191);
        send_marker(16'd8189, 8'hEF, 8'hDF, 8'hCF);
        drain_writes();
    endtask

    // The sink holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        apply_screen(3200, 800, 600);
        sender_quiet = 1'b1;
        sink_hold_req = 400;
        repeat (4) send_random_color(visible_index());
        drain_writes();
        sink_quiet = 1'b1;
        repeat (4) send_random_color(visible_index());
        drain_writes();
        sink_quiet   = 1'b0;
        sender_quiet = 1'b0;
    endtask

    task automatic test_random_markers();
        int unsigned width, height;
        for (int round = 0; round < 4; round++) begin
            width  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(60, 1200);
            height = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(10, 800);
            apply_screen($urandom_range(0, 65535), width, height);
            apply_color($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 4095));
            sink_quiet   = (round == 2);
            sender_quiet = (round == 2);
            for (int k = 0; k < 45; k++) begin
                if ($urandom_range(0, 6) == 0)
                    send_random_color(IDX_W'($urandom_range(0, 65535)));
                else
                    send_random_color(visible_index());
            end
            drain_writes();
        end
        sink_quiet   = 1'b0;
        sender_quiet = 1'b0;
    endtask

    initial begin : main_flow
        shadow_pitch       = '0;
        shadow_width       = '0;
        shadow_height      = '0;
        shadow_red_shift   = 5'd16;
        shadow_green_shift = 5'd8;
        shadow_blue_shift  = 5'd0;
        shadow_widths      = 12'h888;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_grid_placement();
        test_clipping();
        test_color_packing();
        test_pitch_extremes();
        test_backpressure();
        test_random_markers();
        drain_writes();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
